// ----- sv/kdce_pkg.sv -----
// Package for the keypad drive command encoder: key masks, register codes,
// result entry type and the motion encoding function. No dependencies.
package kdce_pkg;

    localparam logic [7:0] BTN_RIGHT    = 8'h01;
    localparam logic [7:0] BTN_BACK     = 8'h02;
    localparam logic [7:0] BTN_MODE     = 8'h04;
    localparam logic [7:0] BTN_LEFT     = 8'h08;
    localparam logic [7:0] BTN_SERVO_DN = 8'h10;
    localparam logic [7:0] BTN_SERVO_UP = 8'h40;
    localparam logic [7:0] BTN_FORWARD  = 8'h80;

    localparam logic [7:0] SWAP_MASK      = 8'h24;
    localparam logic [7:0] CMD_RESET      = 8'h80;
    localparam logic [1:0] SERVO_RESET    = 2'd2;
    localparam logic [1:0] SERVO_MAX      = 2'd3;
    localparam logic [1:0] SERVO_MIN      = 2'd0;

    localparam logic [15:0] RESEND_PERIOD_RESET = 16'd10000;
    localparam logic [7:0]  SERVO_HOLDOFF_RESET = 8'd100;
    localparam logic [7:0]  MODE_HOLDOFF_RESET  = 8'd100;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEYS = 1'b1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_RESEND_PERIOD = 2'd0;
    localparam logic [1:0] REG_SERVO_HOLDOFF = 2'd1;
    localparam logic [1:0] REG_MODE_HOLDOFF  = 2'd2;

    localparam int PADDR_W   = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] drive_command;
        logic       is_resend;
        logic       swap_mode;
        logic       last_of_run;
    } result_t;

    // b1:0 left speed, b2 left reverse, b4:3 right speed, b5 right reverse
    function automatic logic [7:0] encode_motion(input logic [7:0] k);
        logic [7:0] c;
        c = 8'h00;
        priority if ((k & BTN_FORWARD) != 8'h00) begin
            priority if ((k & BTN_LEFT) != 8'h00)       c = {2'b00, 1'b0, 2'd3, 1'b0, 2'd2};
            else if ((k & BTN_RIGHT) != 8'h00)          c = {2'b00, 1'b0, 2'd2, 1'b0, 2'd3};
            else                                        c = {2'b00, 1'b0, 2'd3, 1'b0, 2'd3};
        end else if ((k & BTN_BACK) != 8'h00) begin
            priority if ((k & BTN_LEFT) != 8'h00)       c = {2'b00, 1'b1, 2'd3, 1'b1, 2'd2};
            else if ((k & BTN_RIGHT) != 8'h00)          c = {2'b00, 1'b1, 2'd2, 1'b1, 2'd3};
            else                                        c = {2'b00, 1'b1, 2'd3, 1'b1, 2'd3};
        end else if ((k & BTN_LEFT) != 8'h00) begin
            c = {2'b00, 1'b0, 2'd1, 1'b1, 2'd1};
        end else if ((k & BTN_RIGHT) != 8'h00) begin
            c = {2'b00, 1'b1, 2'd1, 1'b0, 2'd1};
        end else begin
            c = 8'h00;
        end
        return c;
    endfunction

endpackage

// ----- sv/keypad_drive_command_encoder_core.sv -----
// Keypad drive command encoder, top level: state update, APB register file
// and a small result buffer. Depends on kdce_pkg.
// Results of an item are in the output buffer the cycle after it is
// accepted. Throughput: one item per cycle while s_ready is high; the
// result side drains one item per cycle while m_ready is high. Items that
// each cause two results are paced by s_ready. s_ready needs two free
// slots of the four-entry result buffer. Reset: aresetn synchronous, active
// low; state, registers and buffer pointers reset at once, no clearing pass.
module keypad_drive_command_encoder_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic [7:0]                   s_keys,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_drive_command,
    output logic                         m_is_resend,
    output logic                         m_swap_mode,
    output logic                         m_last_of_run,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kdce_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [15:0] resend_period_reg;
    logic [7:0]  servo_holdoff_reg;
    logic [7:0]  mode_holdoff_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resend_period_reg <= kdce_pkg::RESEND_PERIOD_RESET;
            servo_holdoff_reg <= kdce_pkg::SERVO_HOLDOFF_RESET;
            mode_holdoff_reg  <= kdce_pkg::MODE_HOLDOFF_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                kdce_pkg::REG_RESEND_PERIOD: resend_period_reg <= pwdata[15:0];
                kdce_pkg::REG_SERVO_HOLDOFF: servo_holdoff_reg <= pwdata[7:0];
                kdce_pkg::REG_MODE_HOLDOFF:  mode_holdoff_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            kdce_pkg::REG_RESEND_PERIOD: prdata = {16'h0000, resend_period_reg};
            kdce_pkg::REG_SERVO_HOLDOFF: prdata = {24'h000000, servo_holdoff_reg};
            kdce_pkg::REG_MODE_HOLDOFF:  prdata = {24'h000000, mode_holdoff_reg};
            default:                     prdata = 32'h00000000;
        endcase
    end

    // ---------------------------------------------------------------
    // Encoder state
    // ---------------------------------------------------------------
    logic [7:0]  prev_keys_reg,   prev_keys_next;
    logic [7:0]  cur_cmd_reg,     cur_cmd_next;
    logic [1:0]  srv_pos_reg,     srv_pos_next;
    logic        swap_reg,        swap_next;
    logic [15:0] resend_cnt_reg,  resend_cnt_next;
    logic [7:0]  servo_cnt_reg,   servo_cnt_next;
    logic [7:0]  mode_cnt_reg,    mode_cnt_next;

    logic        in_acc;
    logic        is_keys;
    logic        resend_due;
    logic        keys_changed;
    logic        up_act;
    logic        down_act;
    logic        mode_act;
    logic [1:0]  pos_up;
    logic [7:0]  new_cmd;
    kdce_pkg::result_t resend_entry;
    kdce_pkg::result_t new_entry;
    kdce_pkg::result_t push0;
    logic [1:0]  push_n;

    assign in_acc       = s_valid && s_ready;
    assign is_keys      = (s_operation == kdce_pkg::OP_KEYS);
    assign resend_due   = (resend_cnt_reg == 16'd0);
    assign keys_changed = (s_keys != prev_keys_reg);

    // servo up is checked first; down sees the countdown as up left it
    assign up_act   = ((s_keys & kdce_pkg::BTN_SERVO_UP) != 8'h00) && (servo_cnt_reg == 8'd0);
    assign pos_up   = (up_act && srv_pos_reg != kdce_pkg::SERVO_MAX) ?
                      srv_pos_reg + 2'd1 : srv_pos_reg;
    assign down_act = ((s_keys & kdce_pkg::BTN_SERVO_DN) != 8'h00) &&
                      (up_act ? (servo_holdoff_reg == 8'd0) : (servo_cnt_reg == 8'd0));
    assign mode_act = ((s_keys & kdce_pkg::BTN_MODE) != 8'h00) && (mode_cnt_reg == 8'd0);

    always_comb begin
        srv_pos_next = pos_up;
        if (down_act && pos_up != kdce_pkg::SERVO_MIN) begin
            srv_pos_next = pos_up - 2'd1;
        end
    end

    // swap mask uses the flag before this item's toggle
    assign new_cmd = (kdce_pkg::encode_motion(s_keys) ^ (swap_reg ? kdce_pkg::SWAP_MASK : 8'h00))
                     | {srv_pos_next, 6'b000000};

    always_comb begin
        prev_keys_next  = prev_keys_reg;
        cur_cmd_next    = cur_cmd_reg;
        swap_next       = swap_reg;
        resend_cnt_next = resend_cnt_reg;
        servo_cnt_next  = servo_cnt_reg;
        mode_cnt_next   = mode_cnt_reg;
        push_n          = 2'd0;
        if (!is_keys) begin
            if (mode_cnt_reg != 8'd0)    mode_cnt_next   = mode_cnt_reg - 8'd1;
            if (servo_cnt_reg != 8'd0)   servo_cnt_next  = servo_cnt_reg - 8'd1;
            if (resend_cnt_reg != 16'd0) resend_cnt_next = resend_cnt_reg - 16'd1;
        end else begin
            if (resend_due || keys_changed) resend_cnt_next = resend_period_reg;
            if (keys_changed) begin
                prev_keys_next = s_keys;
                cur_cmd_next   = new_cmd;
                if (up_act || down_act) servo_cnt_next = servo_holdoff_reg;
                if (mode_act) begin
                    swap_next     = ~swap_reg;
                    mode_cnt_next = mode_holdoff_reg;
                end
            end
            push_n = {1'b0, resend_due} + {1'b0, keys_changed};
        end
    end

    // both results report the flag as it stands after the item
    assign resend_entry = '{drive_command: cur_cmd_reg, is_resend: 1'b1,
                            swap_mode: swap_next, last_of_run: !keys_changed};
    assign new_entry    = '{drive_command: new_cmd, is_resend: 1'b0,
                            swap_mode: swap_next, last_of_run: 1'b1};
    assign push0        = resend_due ? resend_entry : new_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_keys_reg  <= 8'h00;
            cur_cmd_reg    <= kdce_pkg::CMD_RESET;
            srv_pos_reg    <= kdce_pkg::SERVO_RESET;
            swap_reg       <= 1'b1;
            resend_cnt_reg <= 16'd0;
            servo_cnt_reg  <= 8'd0;
            mode_cnt_reg   <= 8'd0;
        end else if (in_acc) begin
            prev_keys_reg  <= prev_keys_next;
            cur_cmd_reg    <= cur_cmd_next;
            if (is_keys && keys_changed) srv_pos_reg <= srv_pos_next;
            swap_reg       <= swap_next;
            resend_cnt_reg <= resend_cnt_next;
            servo_cnt_reg  <= servo_cnt_next;
            mode_cnt_reg   <= mode_cnt_next;
        end
    end

    // ---------------------------------------------------------------
    // Result buffer: up to two writes per item, one read per m_ready cycle
    // ---------------------------------------------------------------
    kdce_pkg::result_t                 fifo_reg [kdce_pkg::FIFO_DEPTH];
    logic [kdce_pkg::PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [kdce_pkg::PTR_W-1:0]        rd_ptr_reg;
    logic [kdce_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [1:0]                        wr_n;
    logic                              out_acc;
    kdce_pkg::result_t                 head;

    assign wr_n    = in_acc ? push_n : 2'd0;
    assign out_acc = m_valid && m_ready;
    assign s_ready = (count_reg <= kdce_pkg::CNT_W'(kdce_pkg::FIFO_DEPTH - 2));
    assign m_valid = (count_reg != '0);

    assign wr_ptr_next = wr_ptr_reg + kdce_pkg::PTR_W'(wr_n);
    assign count_next  = count_reg + kdce_pkg::CNT_W'(wr_n) - kdce_pkg::CNT_W'(out_acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (out_acc) rd_ptr_reg <= rd_ptr_reg + kdce_pkg::PTR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_n != 2'd0) fifo_reg[wr_ptr_reg] <= push0;
        if (wr_n == 2'd2) fifo_reg[wr_ptr_reg + kdce_pkg::PTR_W'(1)] <= new_entry;
    end

    assign head            = fifo_reg[rd_ptr_reg];
    assign m_drive_command = head.drive_command;
    assign m_is_resend     = head.is_resend;
    assign m_swap_mode     = head.swap_mode;
    assign m_last_of_run   = head.last_of_run;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= kdce_pkg::CNT_W'(kdce_pkg::FIFO_DEPTH))
        else $error("result buffer overflow");

    a_tick_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_operation == kdce_pkg::OP_TICK) |=> (count_reg <= $past(count_reg)))
        else $error("tick produced a result");

    a_prev_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_operation == kdce_pkg::OP_KEYS) |=> (prev_keys_reg == $past(s_keys)))
        else $error("previous keys not captured");

    a_resend_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_operation == kdce_pkg::OP_KEYS && resend_cnt_reg == 16'd0)
        |=> (resend_cnt_reg == $past(resend_period_reg)))
        else $error("resend countdown not reloaded");
`endif

endmodule

// ----- verif/keypad_drive_command_encoder_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for keypad_drive_command_encoder_core.
// Depends on kdce_pkg and the core; predicts every drive command in-bench and
// checks results in order while both channels idle at random.
module keypad_drive_command_encoder_core_tb;
    import kdce_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam logic [7:0]  BTN_SPARE      = 8'h20;   // b5, no function
    localparam logic [7:0]  BTN_MOTION     = BTN_FORWARD | BTN_BACK | BTN_LEFT | BTN_RIGHT;
    localparam logic [8:0]  TICK           = {OP_TICK, 8'h00};

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_operation;
    logic [7:0]           s_keys;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_drive_command;
    logic                 m_is_resend;
    logic                 m_swap_mode;
    logic                 m_last_of_run;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    keypad_drive_command_encoder_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_keys          (s_keys),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_command (m_drive_command),
        .m_is_resend     (m_is_resend),
        .m_swap_mode     (m_swap_mode),
        .m_last_of_run   (m_last_of_run),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the encoder and its registers
    // ------------------------------------------------------------------
    logic [15:0] cfg_resend_period;
    logic [7:0]  cfg_servo_holdoff;
    logic [7:0]  cfg_mode_holdoff;

    logic [7:0]  last_keys;
    logic [7:0]  held_command;
    logic [1:0]  srv_pos;
    logic        swap_on;
    logic [15:0] resend_timer;
    logic [7:0]  srv_timer;
    logic [7:0]  mode_timer;

    result_t     pending_commands [$];   // expected results, oldest first

    // idling controls, changed per test
    int tx_max_gap;
    int rx_max_stall;

    // bookkeeping
    int error_count;
    int ticks_sent;
    int samples_sent;
    int commands_checked;
    int resends_seen;
    int settings_used;
    int stalled_cycles;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Track bits of the motion part: {r_rev, r_spd, l_rev, l_spd}.
    // Forward beats back, left beats right; a curve slows the inner track
    // by one; left or right alone turns in place at speed one.
    function automatic logic [7:0] motion_bits(input logic [7:0] k);
        logic [1:0] l_spd;
        logic [1:0] r_spd;
        logic       l_rev;
        logic       r_rev;
        l_spd = 2'd0;
        r_spd = 2'd0;
        l_rev = 1'b0;
        r_rev = 1'b0;
        if ((k & (BTN_FORWARD | BTN_BACK)) != 8'h00) begin
            r_rev = (k & BTN_FORWARD) == 8'h00;
            l_rev = r_rev;
            l_spd = ((k & BTN_LEFT) != 8'h00) ? 2'd2 : 2'd3;
            r_spd = ((k & BTN_LEFT) == 8'h00 && (k & BTN_RIGHT) != 8'h00) ? 2'd2 : 2'd3;
        end else if ((k & BTN_LEFT) != 8'h00) begin
            l_spd = 2'd1;
            l_rev = 1'b1;
            r_spd = 2'd1;
        end else if ((k & BTN_RIGHT) != 8'h00) begin
            l_spd = 2'd1;
            r_spd = 2'd1;
            r_rev = 1'b1;
        end
        return {2'b00, r_rev, r_spd, l_rev, l_spd};
    endfunction

    task automatic reset_predictor();
        cfg_resend_period = RESEND_PERIOD_RESET;
        cfg_servo_holdoff = SERVO_HOLDOFF_RESET;
        cfg_mode_holdoff  = MODE_HOLDOFF_RESET;
        last_keys         = 8'h00;
        held_command      = CMD_RESET;
        srv_pos           = SERVO_RESET;
        swap_on           = 1'b1;
        resend_timer      = 16'd0;
        srv_timer         = 8'd0;
        mode_timer        = 8'd0;
    endtask

    // Work out the results of one accepted item and queue them.
    task automatic predict_drive_results(input logic op, input logic [7:0] k);
        result_t    run [$];
        result_t    r;
        logic [7:0] cmd;
        if (op == OP_TICK) begin
            if (mode_timer != 8'd0) mode_timer--;
            if (srv_timer != 8'd0) srv_timer--;
            if (resend_timer != 16'd0) resend_timer--;
            return;
        end
        // periodic re-send of the held command comes first
        if (resend_timer == 16'd0) begin
            resend_timer    = cfg_resend_period;
            r.drive_command = held_command;
            r.is_resend     = 1'b1;
            r.swap_mode     = 1'b0;
            r.last_of_run   = 1'b0;
            run.push_back(r);
        end
        if (k != last_keys) begin
            last_keys    = k;
            resend_timer = cfg_resend_period;
            cmd          = motion_bits(k);
            if (swap_on) cmd ^= SWAP_MASK;
            // up goes first: the up step arms the hold-off before down is checked
            if ((k & BTN_SERVO_UP) != 8'h00 && srv_timer == 8'd0) begin
                if (srv_pos != SERVO_MAX) srv_pos++;
                srv_timer = cfg_servo_holdoff;
            end
            if ((k & BTN_SERVO_DN) != 8'h00 && srv_timer == 8'd0) begin
                if (srv_pos != SERVO_MIN) srv_pos--;
                srv_timer = cfg_servo_holdoff;
            end
            cmd[7:6]        = srv_pos;
            held_command    = cmd;
            r.drive_command = cmd;
            r.is_resend     = 1'b0;
            r.swap_mode     = 1'b0;
            r.last_of_run   = 1'b0;
            run.push_back(r);
            // mode toggle lands after encoding, so only later commands see it
            if ((k & BTN_MODE) != 8'h00 && mode_timer == 8'd0) begin
                swap_on    = ~swap_on;
                mode_timer = cfg_mode_holdoff;
            end
        end
        foreach (run[i]) begin
            run[i].swap_mode   = swap_on;
            run[i].last_of_run = (i == run.size() - 1);
            pending_commands.push_back(run[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: one item per call, random gap first. Valid stays high
    // across back-to-back items so it is never dropped and raised in the
    // same step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [7:0] k);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_keys      <= k;
        do @(posedge aclk); while (!s_ready);
        predict_drive_results(op, k);
        if (op == OP_TICK) ticks_sent++;
        else samples_sent++;
    endtask

    // Stop sending and wait for every expected command. A trailing tick
    // leaves nothing to wait on, so wait on past the empty queue for it to land.
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (pending_commands.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write, then a back-to-back read of the same register.
    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        logic [31:0] mask;
        mask = (idx == REG_RESEND_PERIOD) ? 32'h0000_ffff : 32'h0000_00ff;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value} & mask;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_RESEND_PERIOD: cfg_resend_period = value;
            REG_SERVO_HOLDOFF: cfg_servo_holdoff = value[7:0];
            REG_MODE_HOLDOFF:  cfg_mode_holdoff  = value[7:0];
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if ((prdata & mask) !== ({16'h0000, value} & mask)) begin
            $display("%0t: register %0d read back: expected %h actual %h",
                     $time, idx, {16'h0000, value} & mask, prdata & mask);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [15:0] resend, input logic [7:0] servo_hold,
                                  input logic [7:0] mode_hold);
        wait_until_idle();
        write_register(REG_RESEND_PERIOD, resend);
        write_register(REG_SERVO_HOLDOFF, {8'h00, servo_hold});
        write_register(REG_MODE_HOLDOFF, {8'h00, mode_hold});
        settings_used++;
    endtask

    task automatic send_sequence(input logic [8:0] seq [$]);
        foreach (seq[i]) send_item(seq[i][8], seq[i][7:0]);
    endtask

    // Mostly plausible key chords; some repeats of the held keys so the
    // re-send path fires, and a few raw bytes as noise.
    function automatic logic [7:0] pick_keys();
        int unsigned sel;
        logic [7:0]  k;
        sel = $urandom_range(0, 9);
        k   = 8'($urandom_range(0, 255));
        if (sel < 3) return last_keys;
        if (sel == 9) return k;
        k &= BTN_MOTION;
        if ($urandom_range(0, 3) == 0) k |= BTN_SERVO_UP;
        if ($urandom_range(0, 3) == 0) k |= BTN_SERVO_DN;
        if ($urandom_range(0, 5) == 0) k |= BTN_MODE;
        return k;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register defaults: the first sample re-sends the reset command with
    // swap set; equal keys then stay quiet.
    task automatic test_power_on_state();
        tx_max_gap   = 14;
        rx_max_stall = 14;
        send_sequence('{{OP_KEYS, 8'h00}, {OP_KEYS, 8'h00}, TICK,
                        {OP_KEYS, BTN_FORWARD}});
    endtask

    // Every motion chord, the spare bit, servo saturation at the top, both
    // servo keys at once, servo hold-off blocking and mode toggles.
    task automatic test_key_encoding();
        apply_settings(16'hffff, 8'd1, 8'd1);
        tx_max_gap   = 14;
        rx_max_stall = 0;
        send_sequence('{
            {OP_KEYS, BTN_FORWARD}, {OP_KEYS, BTN_FORWARD | BTN_LEFT},
            {OP_KEYS, BTN_FORWARD | BTN_RIGHT}, {OP_KEYS, BTN_BACK},
            {OP_KEYS, BTN_BACK | BTN_LEFT}, {OP_KEYS, BTN_BACK | BTN_RIGHT},
            {OP_KEYS, BTN_LEFT}, {OP_KEYS, BTN_RIGHT}, {OP_KEYS, 8'h00},
            {OP_KEYS, BTN_SPARE}, {OP_KEYS, BTN_SPARE}, {OP_KEYS, 8'hff}, TICK,
            {OP_KEYS, BTN_SERVO_UP}, TICK, {OP_KEYS, 8'h00}, {OP_KEYS, BTN_SERVO_UP},
            TICK, {OP_KEYS, BTN_SERVO_UP | BTN_SERVO_DN}, TICK,
            {OP_KEYS, BTN_SERVO_DN}, {OP_KEYS, 8'h00}, {OP_KEYS, BTN_SERVO_DN},
            TICK, {OP_KEYS, BTN_MODE}});
    endtask

    // Zero registers: all samples but the first re-send, no hold-offs, so
    // the servo walks to the bottom stop and mode toggles on every press.
    task automatic test_zero_registers();
        apply_settings(16'd0, 8'd0, 8'd0);
        tx_max_gap   = 0;
        rx_max_stall = 14;
        send_sequence('{
            {OP_KEYS, BTN_SERVO_DN}, {OP_KEYS, 8'h00}, {OP_KEYS, BTN_SERVO_DN},
            {OP_KEYS, 8'h00}, {OP_KEYS, BTN_SERVO_DN}, {OP_KEYS, 8'h00},
            {OP_KEYS, BTN_SERVO_DN}, {OP_KEYS, BTN_MODE}, {OP_KEYS, 8'h00},
            {OP_KEYS, BTN_MODE | BTN_BACK}, {OP_KEYS, BTN_MODE | BTN_BACK}, TICK});
    endtask

    // Re-send countdown at the short end, and the longest hold-offs.
    task automatic test_resend_timing();
        apply_settings(16'd1, 8'd255, 8'd255);
        tx_max_gap   = 3;
        rx_max_stall = 3;
        send_sequence('{
            {OP_KEYS, BTN_FORWARD}, {OP_KEYS, BTN_FORWARD}, TICK,
            {OP_KEYS, BTN_FORWARD}, {OP_KEYS, BTN_FORWARD}, TICK, TICK,
            {OP_KEYS, BTN_FORWARD | BTN_MODE}, {OP_KEYS, BTN_MODE}});
        apply_settings(16'd3, 8'd2, 8'd3);
        send_sequence('{
            {OP_KEYS, BTN_RIGHT | BTN_SERVO_UP}, TICK, TICK, {OP_KEYS, BTN_RIGHT},
            TICK, {OP_KEYS, BTN_RIGHT}, {OP_KEYS, BTN_SERVO_UP}, TICK,
            {OP_KEYS, BTN_SERVO_UP}});
    endtask

    task automatic run_random_phase(input int n_items, input int tick_pct, input bit pause);
        logic       op;
        logic [7:0] k;
        for (int i = 0; i < n_items; i++) begin
            // the sender holds off once mid-phase until all commands are in
            if (pause && i == n_items / 2) wait_until_idle();
            op = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_KEYS;
            k  = 8'($urandom_range(0, 255));
            if (op == OP_KEYS) k = pick_keys();
            send_item(op, k);
        end
    endtask

    // Random chords and ticks under several register settings, with and
    // without idling on either side.
    task automatic test_random_traffic();
        apply_settings(16'd5, 8'd3, 8'd3);
        tx_max_gap   = 14;
        rx_max_stall = 14;
        run_random_phase(120, 40, 1'b1);

        apply_settings(16'd1, 8'd1, 8'd1);
        tx_max_gap   = 0;
        rx_max_stall = 0;
        run_random_phase(120, 30, 1'b0);

        apply_settings(16'd0, 8'd0, 8'd0);
        tx_max_gap   = 3;
        rx_max_stall = 14;
        run_random_phase(100, 30, 1'b0);

        apply_settings(16'hffff, 8'd255, 8'd255);
        tx_max_gap   = 14;
        rx_max_stall = 0;
        run_random_phase(100, 50, 1'b0);

        for (int p = 0; p < 4; p++) begin
            apply_settings(16'($urandom_range(1, 30)), 8'($urandom_range(1, 10)),
                           8'($urandom_range(1, 10)));
            tx_max_gap   = $urandom_range(0, 1) * 14;
            rx_max_stall = $urandom_range(0, 14);
            run_random_phase(40, $urandom_range(20, 60), p == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall before each item, ready held high across
    // back-to-back results.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = $urandom_range(0, rx_max_stall);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_commands.size() == 0) begin
                $display("%0t: unexpected result: expected none actual cmd %h",
                         $time, m_drive_command);
                error_count++;
            end else begin
                want = pending_commands.pop_front();
                if (m_drive_command !== want.drive_command) begin
                    $display("%0t: drive_command expected %h actual %h",
                             $time, want.drive_command, m_drive_command);
                    error_count++;
                end
                if (m_is_resend !== want.is_resend) begin
                    $display("%0t: is_resend expected %b actual %b",
                             $time, want.is_resend, m_is_resend);
                    error_count++;
                end
                if (m_swap_mode !== want.swap_mode) begin
                    $display("%0t: swap_mode expected %b actual %b",
                             $time, want.swap_mode, m_swap_mode);
                    error_count++;
                end
                if (m_last_of_run !== want.last_of_run) begin
                    $display("%0t: last_of_run expected %b actual %b",
                             $time, want.last_of_run, m_last_of_run);
                    error_count++;
                end
                commands_checked++;
                if (want.is_resend) resends_seen++;
            end
        end
    end

    // Watchdog: ends a run in which nothing moves on any port.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) stalled_cycles <= 0;
        else stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, nothing accepted for %0d cycles, %0d results pending",
                     $time, WATCHDOG_LIMIT, pending_commands.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        error_count      = 0;
        ticks_sent       = 0;
        samples_sent     = 0;
        commands_checked = 0;
        resends_seen     = 0;
        settings_used    = 1;   // reset defaults
        stalled_cycles   = 0;
        tx_max_gap       = 0;
        rx_max_stall     = 0;
        reset_predictor();

        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_operation <= OP_TICK;
        s_keys      <= 8'h00;
        m_ready     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= 32'h0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_power_on_state();
        test_key_encoding();
        test_zero_registers();
        test_resend_timing();
        test_random_traffic();

        // drain, then keep watching for stray results
        wait_until_idle();
        repeat (8) @(posedge aclk);

        $display("Run covered %0d key samples and %0d ticks under %0d register settings;",
                 samples_sent, ticks_sent, settings_used);
        $display("%0d drive commands checked, %0d of them periodic re-sends.",
                 commands_checked, resends_seen);
        if (error_count == 0 && pending_commands.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
